// File: hdl/drx_pkg.sv
// ----------------------------------------------------------------------------
// drx_pkg
// Shared types and constants of the DNS response address extractor.
// ----------------------------------------------------------------------------
package drx_pkg;

    // Largest answer count that a response may carry.
    localparam int unsigned MAX_ANSWERS = 8;

    // Entries of the queue between parser and output stage (power of two).
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Status codes reported in the final word of a packet.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_QCOUNT    = 3'd1;
    localparam logic [2:0] ST_ACOUNT    = 3'd2;
    localparam logic [2:0] ST_AUTHORITY = 3'd3;
    localparam logic [2:0] ST_ADDITIONAL = 3'd4;
    localparam logic [2:0] ST_DATA_LEN  = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    // Record types and address lengths.
    localparam logic [7:0] TYPE_A_LO    = 8'd1;
    localparam logic [7:0] TYPE_AAAA_LO = 8'd28;
    localparam logic [7:0] LEN_V4       = 8'd4;
    localparam logic [7:0] LEN_V6       = 8'd16;
    localparam logic [7:0] PTR_MARK     = 8'd192;

    // What one packet byte produces: an address word, a status word, or both.
    typedef struct packed {
        logic       has_addr;
        logic [7:0] addr_byte;
        logic [2:0] answer_number;
        logic [3:0] byte_number;
        logic       has_status;
        logic [2:0] status_code;
        logic [3:0] found_count;
    } t_drx_event;

endpackage

// File: hdl/drx_in_if.sv
// ----------------------------------------------------------------------------
// drx_in_if
// Packet byte channel: one byte and its end-of-packet mark per word.
// ----------------------------------------------------------------------------
interface drx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_packet;

    modport source (output valid, output rx_byte, output end_of_packet, input ready);
    modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

// File: hdl/drx_out_if.sv
// ----------------------------------------------------------------------------
// drx_out_if
// Result channel: address byte words and the per-packet status word.
// ----------------------------------------------------------------------------
interface drx_out_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [7:0] addr_byte;
    logic [2:0] answer_number;
    logic [3:0] byte_number;
    logic [2:0] status_code;
    logic [3:0] found_count;

    modport source (output valid, output is_status, output addr_byte,
                    output answer_number, output byte_number, output status_code,
                    output found_count, input ready);
    modport sink   (input valid, input is_status, input addr_byte,
                    input answer_number, input byte_number, input status_code,
                    input found_count, output ready);
endinterface

// File: hdl/drx_front.sv
// ----------------------------------------------------------------------------
// drx_front
// Byte parser: walks header, question and answers and classifies each byte.
// ----------------------------------------------------------------------------
module drx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_end_of_packet,
    input  logic                i_want_ipv6,
    output logic                o_event_valid,
    output drx_pkg::t_drx_event o_event
);

    localparam logic [3:0] PH_HDR   = 4'd0;
    localparam logic [3:0] PH_QNAME = 4'd1;
    localparam logic [3:0] PH_QPTR  = 4'd2;
    localparam logic [3:0] PH_QFIX  = 4'd3;
    localparam logic [3:0] PH_ANAME = 4'd4;
    localparam logic [3:0] PH_APTR  = 4'd5;
    localparam logic [3:0] PH_AFIX  = 4'd6;
    localparam logic [3:0] PH_RDATA = 4'd7;
    localparam logic [3:0] PH_DONE  = 4'd8;
    localparam logic [3:0] PH_DRAIN = 4'd9;

    logic [3:0] r_phase,   n_phase;
    logic [3:0] r_cnt,     n_cnt;
    logic       r_qhi,     n_qhi;
    logic       r_ahi,     n_ahi;
    logic [3:0] r_atotal,  n_atotal;
    logic [3:0] r_done,    n_done;
    logic [7:0] r_label,   n_label;
    logic       r_thi0,    n_thi0;
    logic [7:0] r_tlo,     n_tlo;
    logic       r_lhi0,    n_lhi0;
    logic       r_len16,   n_len16;
    logic [2:0] r_err,     n_err;
    logic [3:0] r_matches, n_matches;

    logic [7:0]          b;
    logic                match;
    logic                last_data;
    drx_pkg::t_drx_event ev;

    assign b         = i_rx_byte;
    assign match     = r_thi0 && (r_tlo == (i_want_ipv6 ? drx_pkg::TYPE_AAAA_LO
                                                        : drx_pkg::TYPE_A_LO));
    assign last_data = (r_cnt == (r_len16 ? 4'd15 : 4'd3));

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_qhi     = r_qhi;
        n_ahi     = r_ahi;
        n_atotal  = r_atotal;
        n_done    = r_done;
        n_label   = r_label;
        n_thi0    = r_thi0;
        n_tlo     = r_tlo;
        n_lhi0    = r_lhi0;
        n_len16   = r_len16;
        n_err     = r_err;
        n_matches = r_matches;
        ev        = '0;

        unique case (r_phase)
            PH_HDR: begin
                if (r_cnt == 4'd4) n_qhi = (b != 8'd0);
                if (r_cnt == 4'd6) n_ahi = (b != 8'd0);
                if (r_cnt == 4'd7) n_atotal = b[3:0];
                priority if (r_cnt == 4'd5 && (r_qhi || b != 8'd1)) begin
                    n_err   = drx_pkg::ST_QCOUNT;
                    n_phase = PH_DRAIN;
                end else if (r_cnt == 4'd7 && (r_ahi || b == 8'd0
                             || b > 8'(drx_pkg::MAX_ANSWERS))) begin
                    n_err   = drx_pkg::ST_ACOUNT;
                    n_phase = PH_DRAIN;
                end else if ((r_cnt == 4'd8 || r_cnt == 4'd9) && b != 8'd0) begin
                    n_err   = drx_pkg::ST_AUTHORITY;
                    n_phase = PH_DRAIN;
                end else if ((r_cnt == 4'd10 || r_cnt == 4'd11) && b != 8'd0) begin
                    n_err   = drx_pkg::ST_ADDITIONAL;
                    n_phase = PH_DRAIN;
                end else if (r_cnt >= 4'd11) begin
                    n_phase = PH_QNAME;
                    n_label = '0;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            PH_QNAME, PH_ANAME: begin
                // Skip label bodies; a zero length ends the name, a pointer ends it
                // after one more byte.
                priority if (r_label != 8'd0) begin
                    n_label = r_label - 8'd1;
                end else if (b == 8'd0) begin
                    n_phase = (r_phase == PH_QNAME) ? PH_QFIX : PH_AFIX;
                    n_cnt   = '0;
                end else if (b >= drx_pkg::PTR_MARK) begin
                    n_phase = (r_phase == PH_QNAME) ? PH_QPTR : PH_APTR;
                end else begin
                    n_label = b;
                end
            end
            PH_QPTR: begin
                n_phase = PH_QFIX;
                n_cnt   = '0;
            end
            PH_APTR: begin
                n_phase = PH_AFIX;
                n_cnt   = '0;
            end
            PH_QFIX: begin
                if (r_cnt >= 4'd3) begin
                    n_phase = PH_ANAME;
                    n_label = '0;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            PH_AFIX: begin
                if (r_cnt == 4'd0) n_thi0 = (b == 8'd0);
                if (r_cnt == 4'd1) n_tlo = b;
                if (r_cnt == 4'd8) n_lhi0 = (b == 8'd0);
                if (r_cnt >= 4'd9) begin
                    if (!r_lhi0 || b != (i_want_ipv6 ? drx_pkg::LEN_V6
                                                     : drx_pkg::LEN_V4)) begin
                        n_err   = drx_pkg::ST_DATA_LEN;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase = PH_RDATA;
                        n_len16 = i_want_ipv6;
                        n_cnt   = '0;
                    end
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            PH_RDATA: begin
                ev.has_addr      = match;
                ev.addr_byte     = b;
                ev.answer_number = r_matches[2:0];
                ev.byte_number   = r_cnt;
                if (last_data) begin
                    if (match) n_matches = r_matches + 4'd1;
                    n_done = r_done + 4'd1;
                    if (n_done >= r_atotal) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_ANAME;
                        n_label = '0;
                    end
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            default: begin
            end
        endcase

        if (i_end_of_packet) begin
            ev.has_status  = 1'b1;
            ev.found_count = n_matches;
            if (n_err != drx_pkg::ST_OK) begin
                ev.status_code = n_err;
            end else if (n_phase == PH_DONE) begin
                ev.status_code = drx_pkg::ST_OK;
            end else begin
                ev.status_code = drx_pkg::ST_TRUNCATED;
            end
            // rearm for the next packet
            n_phase   = PH_HDR;
            n_cnt     = '0;
            n_qhi     = 1'b0;
            n_ahi     = 1'b0;
            n_atotal  = '0;
            n_done    = '0;
            n_label   = '0;
            n_thi0    = 1'b0;
            n_tlo     = '0;
            n_lhi0    = 1'b0;
            n_len16   = 1'b0;
            n_err     = drx_pkg::ST_OK;
            n_matches = '0;
        end
    end

    assign o_event       = ev;
    assign o_event_valid = i_accept && (ev.has_addr || ev.has_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR;
            r_cnt     <= '0;
            r_qhi     <= 1'b0;
            r_ahi     <= 1'b0;
            r_atotal  <= '0;
            r_done    <= '0;
            r_label   <= '0;
            r_thi0    <= 1'b0;
            r_tlo     <= '0;
            r_lhi0    <= 1'b0;
            r_len16   <= 1'b0;
            r_err     <= drx_pkg::ST_OK;
            r_matches <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_qhi     <= n_qhi;
            r_ahi     <= n_ahi;
            r_atotal  <= n_atotal;
            r_done    <= n_done;
            r_label   <= n_label;
            r_thi0    <= n_thi0;
            r_tlo     <= n_tlo;
            r_lhi0    <= n_lhi0;
            r_len16   <= n_len16;
            r_err     <= n_err;
            r_matches <= n_matches;
        end
    end

    a_err_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != drx_pkg::ST_OK) |-> (r_phase == PH_DRAIN))
        else $error("error latched outside drain phase");

    a_matches_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matches <= r_done)
        else $error("more matches than completed answers");

    a_event_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid |-> i_accept)
        else $error("event produced without an accepted byte");

endmodule

// File: hdl/drx_queue.sv
// ----------------------------------------------------------------------------
// drx_queue
// Short register queue of parser events between parser and output stage.
// ----------------------------------------------------------------------------
module drx_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  drx_pkg::t_drx_event i_event,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output drx_pkg::t_drx_event o_event
);

    drx_pkg::t_drx_event r_mem [drx_pkg::QUEUE_DEPTH];
    logic [drx_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [drx_pkg::QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == drx_pkg::QCNT_W'(drx_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_event;
    end

    // pointers wrap naturally since the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule

// File: hdl/drx_back.sv
// ----------------------------------------------------------------------------
// drx_back
// Output stage: turns queued events into address and status words.
// ----------------------------------------------------------------------------
module drx_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  drx_pkg::t_drx_event i_q_event,
    output logic                o_pop,
    drx_out_if.source           o_out
);

    logic                r_valid;
    logic                r_addr_sent;
    drx_pkg::t_drx_event r_ev;

    logic show_addr;
    logic last_word;
    logic take;

    assign show_addr = r_ev.has_addr && !r_addr_sent;
    // the address word goes first when one byte yields both words
    assign last_word = !(show_addr && r_ev.has_status);
    assign take      = r_valid && o_out.ready;
    assign o_pop     = i_q_valid && (!r_valid || (take && last_word));

    assign o_out.valid         = r_valid;
    assign o_out.is_status     = !show_addr;
    assign o_out.addr_byte     = show_addr ? r_ev.addr_byte : 8'd0;
    assign o_out.answer_number = show_addr ? r_ev.answer_number : 3'd0;
    assign o_out.byte_number   = show_addr ? r_ev.byte_number : 4'd0;
    assign o_out.status_code   = show_addr ? drx_pkg::ST_OK : r_ev.status_code;
    assign o_out.found_count   = show_addr ? 4'd0 : r_ev.found_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_addr_sent <= 1'b0;
        end else if (o_pop) begin
            r_valid     <= 1'b1;
            r_addr_sent <= 1'b0;
        end else if (take) begin
            if (last_word) begin
                r_valid     <= 1'b0;
                r_addr_sent <= 1'b0;
            end else begin
                r_addr_sent <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_ev <= i_q_event;
    end

    a_sent_only_for_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr_sent |-> (r_valid && r_ev.has_addr && r_ev.has_status))
        else $error("address marked sent without a pending status word");

    a_pending_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_ev.has_addr || r_ev.has_status))
        else $error("empty event held in output stage");

endmodule

// File: hdl/dns_response_address_extractor_unit.sv
// ----------------------------------------------------------------------------
// dns_response_address_extractor_unit
// Streams a DNS response and emits matching A or AAAA address bytes plus a
// final status word per packet.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle, with no gaps needed between bytes or
// packets. Each byte is handled by one registered parser update; bytes that
// yield a word pass through a four-entry queue to the output register. The
// last byte of a packet may yield two words (address then status), which the
// output stage sends one after the other; the queue absorbs this and short
// output stalls. The input only stalls once the queue is full. Write
// want_ipv6 only between packets.
module dns_response_address_extractor_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    drx_in_if.sink    i_in,
    drx_out_if.source o_out
);

    logic                r_want_ipv6;
    logic                accept;
    logic                ev_valid;
    drx_pkg::t_drx_event ev;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    drx_pkg::t_drx_event q_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want_ipv6 <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_want_ipv6 <= i_cfg_wr_data;
        end
    end

    assign i_in.ready = !q_full;
    assign accept     = i_in.valid && !q_full;

    drx_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_rx_byte       (i_in.rx_byte),
        .i_end_of_packet (i_in.end_of_packet),
        .i_want_ipv6     (r_want_ipv6),
        .o_event_valid   (ev_valid),
        .o_event         (ev)
    );

    drx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_valid),
        .i_event (ev),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_event (q_ev)
    );

    drx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_event (q_ev),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
